// ===== hdl/pip_pkg.sv =====
// Shared types, codes and constants of the point-in-polygon tester.
package pip_pkg;

    localparam int COORD_BITS       = 16;
    localparam int COUNT_BITS       = 7;
    localparam int REQ_BITS         = 2;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [REQ_BITS-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_QUERY  = 2'd2;

    typedef struct packed {
        logic [REQ_BITS-1:0]          req_type;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } t_req;

    typedef struct packed {
        logic                  inside_res;
        logic                  status;
        logic [COUNT_BITS-1:0] vertex_count;
    } t_res;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_CLEAR,
        OP_QUERY,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                          op;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QRD,
        S_QDRAIN,
        S_DONE
    } t_bstate;

endpackage

// ===== hdl/point_in_polygon_tester_top.sv =====
// Top level of the point-in-polygon tester: front decoder, command queue, back end.
//
// Usage: the request side is a queue input. A word (req_type, point_x, point_y)
// is taken at a rising edge with push high and full low. req_type 0 appends a
// vertex, 1 clears the polygon, 2 tests a point, 3 is ignored. The result side
// is a queue output: while empty is low, o_res holds the oldest result
// (inside_res, status, vertex_count), taken at an edge with pop high.
// Exactly one result comes back per request word, in request order.
// A query over N > 0 stored vertices: the back end reads one vertex per cycle
// from its single read port (N + 1 reads, closing vertex first) and runs each
// edge through a three-stage subtract / multiply / compare pipeline. The back
// end works on one word at a time; a two-word command queue lets requests
// arrive while it works.
// A stalled receiver holds the result register; the back end then holds its
// finished item and the queue fills, raising full.
// Reset (synchronous, active low) empties the queue and the result register
// and sets the vertex count to zero; the vertex memory is not cleared.
module point_in_polygon_tester_top #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  pip_pkg::t_req i_req,
    output logic          empty,
    input  logic          pop,
    output pip_pkg::t_res o_res
);
    import pip_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic res_valid;

    pip_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (i_req),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    pip_back #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_res_valid(res_valid),
        .o_res      (o_res),
        .i_res_pop  (pop)
    );

    assign empty = !res_valid;

    a_drop_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.status) |-> !o_res.inside_res)
        else $error("dropped append reported inside");

    a_drop_at_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.status) |->
        (int'(o_res.vertex_count) == (MAX_VERTICES % (1 << COUNT_BITS))))
        else $error("dropped append with store not full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (int'(o_res.vertex_count) <= MAX_VERTICES))
        else $error("vertex count above capacity");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

// ===== hdl/pip_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pip_front.sv =====
// Front end: decodes request words into commands and queues them for the back end.
module pip_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  pip_pkg::t_req i_req,
    output logic          o_cmd_valid,
    output pip_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import pip_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       wr_en;
    logic       rd_en;

    always_comb begin
        n_cmd.px = i_req.point_x[COORD_BITS-1:0];
        n_cmd.py = i_req.point_y[COORD_BITS-1:0];
        unique case (i_req.req_type)
            REQ_APPEND: n_cmd.op = OP_APPEND;
            REQ_CLEAR:  n_cmd.op = OP_CLEAR;
            REQ_QUERY:  n_cmd.op = OP_QUERY;
            default:    n_cmd.op = OP_NONE;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign wr_en       = push && !full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= !r_wp;
            end
            if (rd_en) begin
                r_rp <= !r_rp;
            end
            unique case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/pip_back.sv =====
// Back end: vertex store, edge walk with crossing test, and the result register.
module pip_back #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  pip_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_valid,
    output pip_pkg::t_res o_res,
    input  logic          i_res_pop
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int EW = CW + COUNT_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int RW = 2 * COORD_BITS;

    t_bstate r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rcnt, n_rcnt;
    logic          r_status, n_status;
    logic          r_inside;
    logic signed [COORD_BITS-1:0] r_px, r_py;

    logic          ram_we, issue, load_res, clr_inside;
    logic [CW-1:0] last_idx, prev_idx;
    logic [AW-1:0] raddr;
    logic [RW-1:0] rdata;

    logic r_rd_v, r_rd_first;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;

    logic r_a_v, r_a_cross;
    logic signed [DW-1:0] r_a_dy, r_a_dx, r_a_ex, r_a_ey;
    logic signed [DW-1:0] n_dy, n_dx, n_ex, n_ey;
    logic n_cross;

    logic r_b_v, r_b_cross, r_b_neg;
    logic signed [PW-1:0] r_b_lhs, r_b_rhs, n_lhs, n_rhs;
    logic c_hit;

    logic          r_res_valid;
    t_res          r_res;
    logic [EW-1:0] count_ext;

    pip_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_VERTICES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_cmd.px, i_cmd.py}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Walk order: last vertex first, then vertex 0 up to the last.
    assign last_idx = r_count - 1'b1;
    assign prev_idx = r_rcnt - 1'b1;
    assign raddr    = (r_rcnt == '0) ? last_idx[AW-1:0] : prev_idx[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rcnt     = r_rcnt;
        n_status   = r_status;
        o_cmd_pop  = 1'b0;
        ram_we     = 1'b0;
        issue      = 1'b0;
        load_res   = 1'b0;
        clr_inside = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_status   = 1'b0;
                    clr_inside = 1'b1;
                    n_rcnt     = '0;
                    unique case (i_cmd.op)
                        OP_APPEND: begin
                            if (r_count < CW'(MAX_VERTICES)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_status = 1'b1;
                            end
                            n_state = S_DONE;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        OP_QUERY: begin
                            n_state = (r_count == '0) ? S_DONE : S_QRD;
                        end
                        OP_NONE: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_QRD: begin
                issue  = 1'b1;
                n_rcnt = r_rcnt + 1'b1;
                if (r_rcnt == r_count) begin
                    n_state = S_QDRAIN;
                end
            end
            S_QDRAIN: begin
                if (!r_rd_v && !r_a_v && !r_b_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_res_valid || i_res_pop) begin
                    load_res = 1'b1;
                    n_state  = S_IDLE;
                end
            end
        endcase
    end

    // Stage A: sides and differences of edge (current, previous).
    assign cur_x   = rdata[RW-1:COORD_BITS];
    assign cur_y   = rdata[COORD_BITS-1:0];
    assign n_cross = (cur_y >= r_py) != (r_prev_y >= r_py);
    assign n_dy    = DW'(r_prev_y) - DW'(cur_y);
    assign n_dx    = DW'(r_px) - DW'(cur_x);
    assign n_ex    = DW'(r_prev_x) - DW'(cur_x);
    assign n_ey    = DW'(r_py) - DW'(cur_y);

    // Stage B: cross products.
    assign n_lhs = r_a_dx * r_a_dy;
    assign n_rhs = r_a_ex * r_a_ey;

    // Stage C: compare, flipped for a falling edge.
    assign c_hit = r_b_v && r_b_cross &&
                   (r_b_neg ? (r_b_lhs >= r_b_rhs) : (r_b_lhs <= r_b_rhs));

    assign count_ext = EW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_px <= i_cmd.px;
            r_py <= i_cmd.py;
        end
        r_rcnt   <= n_rcnt;
        r_status <= n_status;
        if (r_rd_v) begin
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
        end
        r_a_cross <= n_cross;
        r_a_dy    <= n_dy;
        r_a_dx    <= n_dx;
        r_a_ex    <= n_ex;
        r_a_ey    <= n_ey;
        r_b_cross <= r_a_cross;
        r_b_neg   <= r_a_dy[DW-1];
        r_b_lhs   <= n_lhs;
        r_b_rhs   <= n_rhs;
        if (clr_inside) begin
            r_inside <= 1'b0;
        end else if (c_hit) begin
            r_inside <= !r_inside;
        end
        if (load_res) begin
            r_res.inside_res   <= r_inside;
            r_res.status       <= r_status;
            r_res.vertex_count <= count_ext[COUNT_BITS-1:0];
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_v      <= 1'b0;
            r_rd_first  <= 1'b0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rd_v      <= issue;
            r_rd_first  <= issue && (r_rcnt == '0);
            // The first word read is the closing vertex: keep it, no edge yet.
            r_a_v       <= r_rd_v && !r_rd_first;
            r_b_v       <= r_a_v;
            r_res_valid <= load_res || (r_res_valid && !i_res_pop);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
